[src/prt_pkg.sv]
// Package for the peer reputation table: constants, command codes, status codes, config indexes, state type.
package prt_pkg;

  localparam int TableEntries = 64;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int CountBits    = 32;
  localparam int MaxPathHops  = 16;
  localparam int KeyBits      = 256;
  // counters, last decay time, key
  localparam int EntryBits    = 4 * CountBits + 64 + KeyBits;

  localparam logic [CountBits-1:0] CntMax = '1;

  typedef enum logic [3:0] {
    CMD_CONN_TIMEOUT = 4'd0,
    CMD_CONN_SUCCESS = 4'd1,
    CMD_HOP_FAIL     = 4'd2,
    CMD_PATH_FAIL    = 4'd3,
    CMD_PATH_SUCCESS = 4'd4,
    CMD_CLEAR        = 4'd5,
    CMD_QUERY_CONN   = 4'd6,
    CMD_QUERY_PATH   = 4'd7,
    CMD_QUERY_ALL    = 4'd8,
    CMD_TICK         = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  localparam logic CFG_PROFILING = 1'b0;
  localparam logic CFG_DECAY     = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UPDATE,
    S_DIV,
    S_MUL,
    S_TICK_RD,
    S_TICK_WAIT,
    S_TICK_UPD,
    S_OUT
  } state_t;

endpackage

[src/peer_reputation_table_core.sv]
// Top level of the peer reputation table: sequencer, shared datapath, entry RAM.
//
// Usage: commands arrive as beats on the in_ channel (key, time, chances and
// hop fields in in_tdata, command code in in_tuser). Each command returns one
// beat on the out_ channel with is_bad and status. Configuration registers
// (profiling enable, decay interval) are written through cfg_we/cfg_index/
// cfg_wdata while the block is idle.
// Timing: one command at a time. A lookup walks the 64 entries in turn through
// the single RAM read port, a read state and a compare state for each entry,
// and stops at the first match. Path or connect queries may then run the
// bit-serial divider, and the overall query forms the 64-bit product. A tick
// reads and checks each entry in turn and rewrites those past the decay interval.
// in_tready is low while a command is at work; the result waits in an output
// register until taken, and the next command is accepted once it is.
// Reset clears the valid bits, the sequencer and the registers to their
// defaults (profiling on, decay interval 15000 ms). Entry contents are not
// cleared; an entry's contents count only when its valid bit is set.
module peer_reputation_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_word0, key_word1, key_word2, key_word3, chances, now_ms, hop_index,
  // path_len, zero pad
  input  logic [367:0] in_tdata,
  // cmd
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // is_bad, status, zero pad
  output logic [7:0]   out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import prt_pkg::*;

  localparam int Cb = CountBits;

  // configuration
  logic        prof_en_r;
  logic [31:0] decay_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_en_r <= 1'b1;
      decay_r   <= 32'd15000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROFILING: prof_en_r <= cfg_wdata[0];
        CFG_DECAY:     decay_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured command
  logic [KeyBits-1:0] key_r;
  logic [31:0]        chances_r;
  logic [63:0]        now_r;
  logic [4:0]         plen_r;
  logic [3:0]         cmd_r;

  state_t state_r, state_nxt;
  logic [IdxBits-1:0] idx_r;
  logic [IdxBits-1:0] hit_idx_r;
  logic               free_r;
  logic [IdxBits-1:0] free_idx_r;
  logic [TableEntries-1:0] valid_r;
  logic               bad_r;
  status_t            status_r;
  logic               out_valid_r;

  // entry RAM
  logic                 ram_we;
  logic [IdxBits-1:0]   ram_addr;
  logic [EntryBits-1:0] ram_wdata, ram_rdata;

  prt_ram #(.Width(EntryBits), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // entry fields
  logic [Cb-1:0] e_good, e_tmo, e_psucc, e_pfail;
  logic [63:0]   e_last;
  logic [KeyBits-1:0] e_key;
  assign {e_key, e_last, e_pfail, e_psucc, e_tmo, e_good} = ram_rdata;

  // entry being worked on
  logic [Cb-1:0] w_good_r, w_tmo_r, w_psucc_r, w_pfail_r;
  logic [63:0]   w_last_r;

  // shared divider / multiplier state
  logic [Cb-1:0] quo_r, rem_r, dvd_r, dvs_r;
  logic [5:0]    dcnt_r;
  logic [63:0]   prod_r;

  logic is_mark, is_query, last_idx;
  assign is_mark  = cmd_r <= CMD_PATH_SUCCESS;
  assign is_query = cmd_r == CMD_QUERY_CONN || cmd_r == CMD_QUERY_PATH ||
                    cmd_r == CMD_QUERY_ALL;
  assign last_idx = idx_r == IdxBits'(TableEntries - 1);

  logic key_eq;
  assign key_eq = valid_r[idx_r] && e_key == key_r;

  // judge inputs for connect/path query
  logic [Cb-1:0] jf, js;
  logic [Cb:0]   jsum;
  assign jf   = (cmd_r == CMD_QUERY_CONN) ? w_tmo_r : w_pfail_r;
  assign js   = (cmd_r == CMD_QUERY_CONN) ? w_good_r : w_psucc_r;
  assign jsum = {1'b0, jf} + {1'b0, js};

  // decay check
  logic [63:0] age;
  logic        decay_hit;
  assign age       = now_r - e_last;
  assign decay_hit = valid_r[idx_r] && e_last < now_r && age > {32'd0, decay_r};

  // saturating add
  logic [Cb:0]   add_a;
  logic [Cb-1:0] add_b, add_res;
  logic [4:0]    plen_c;
  assign plen_c = (plen_r > 5'(MaxPathHops)) ? 5'(MaxPathHops) : plen_r;
  always_comb begin
    unique case (cmd_r)
      CMD_CONN_TIMEOUT: add_b = w_tmo_r;
      CMD_CONN_SUCCESS: add_b = w_good_r;
      CMD_PATH_SUCCESS: add_b = w_psucc_r;
      default:          add_b = w_pfail_r;
    endcase
    add_a   = {1'b0, add_b} + ((cmd_r == CMD_PATH_SUCCESS) ?
              (Cb+1)'(plen_c) : (Cb+1)'(1));
    add_res = add_a[Cb] ? CntMax : add_a[Cb-1:0];
  end

  // divider step
  logic [Cb:0] rem_sh;
  assign rem_sh = {rem_r, dvd_r[Cb-1]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        unique case (in_tuser)
          CMD_CONN_TIMEOUT, CMD_CONN_SUCCESS, CMD_HOP_FAIL, CMD_PATH_SUCCESS,
          CMD_CLEAR: state_nxt = S_SCAN_RD;
          CMD_PATH_FAIL: state_nxt = (in_tdata[355:352] == 4'd0) ? S_OUT : S_SCAN_RD;
          CMD_QUERY_CONN, CMD_QUERY_PATH, CMD_QUERY_ALL:
            state_nxt = prof_en_r ? S_SCAN_RD : S_OUT;
          CMD_TICK: state_nxt = S_TICK_RD;
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (key_eq) state_nxt = S_UPDATE;
        else if (last_idx) state_nxt = (is_mark && (free_r || !valid_r[idx_r])) ?
                                       S_UPDATE : S_OUT;
        else state_nxt = S_SCAN_RD;
      end
      S_UPDATE: begin
        if (cmd_r == CMD_QUERY_ALL) state_nxt = S_MUL;
        else if (is_query && jf != '0 && jsum >= {1'b0, chances_r}) state_nxt = S_DIV;
        else state_nxt = S_OUT;
      end
      S_DIV:  if (dcnt_r == 6'(Cb)) state_nxt = S_OUT;
      S_MUL:  state_nxt = S_OUT;
      S_TICK_RD:   state_nxt = S_TICK_WAIT;
      S_TICK_WAIT: state_nxt = S_TICK_UPD;
      S_TICK_UPD:  state_nxt = last_idx ? S_OUT : S_TICK_RD;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_r;
    ram_wdata = {key_r, w_last_r, w_pfail_r, w_psucc_r, w_tmo_r, w_good_r};
    unique case (state_r)
      S_UPDATE: begin
        ram_addr = hit_idx_r;
        if (is_mark) begin
          ram_we = 1'b1;
          unique case (cmd_r)
            CMD_CONN_TIMEOUT: ram_wdata[2*Cb-1:Cb] = add_res;
            CMD_CONN_SUCCESS: ram_wdata[Cb-1:0] = add_res;
            CMD_PATH_SUCCESS: ram_wdata[3*Cb-1:2*Cb] = add_res;
            default:          ram_wdata[4*Cb-1:3*Cb] = add_res;
          endcase
        end
      end
      S_TICK_UPD: begin
        ram_we    = decay_hit;
        ram_wdata = {e_key, now_r, 1'b0, e_pfail[Cb-1:1], 1'b0, e_psucc[Cb-1:1],
                     1'b0, e_tmo[Cb-1:1], 1'b0, e_good[Cb-1:1]};
      end
      default: ;
    endcase
  end

  assign in_tready  = state_r == S_IDLE && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, status_r, bad_r};

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          idx_r    <= '0;
          free_r   <= 1'b0;
          // result fields clear only on a new beat, a waiting result holds
          if (in_tvalid && in_tready) begin
            bad_r     <= 1'b0;
            status_r  <= ST_OK;
            key_r     <= in_tdata[255:0];
            chances_r <= in_tdata[287:256];
            now_r     <= in_tdata[351:288];
            plen_r    <= in_tdata[360:356];
            cmd_r     <= in_tuser;
          end
        end
        S_SCAN_CMP: begin
          if (!valid_r[idx_r] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= idx_r;
          end
          if (key_eq) begin
            hit_idx_r <= idx_r;
            w_good_r  <= e_good;
            w_tmo_r   <= e_tmo;
            w_psucc_r <= e_psucc;
            w_pfail_r <= e_pfail;
            w_last_r  <= e_last;
          end else if (last_idx) begin
            if (is_mark && (free_r || !valid_r[idx_r])) begin
              hit_idx_r <= free_r ? free_idx_r : idx_r;
              w_good_r  <= '0;
              w_tmo_r   <= '0;
              w_psucc_r <= '0;
              w_pfail_r <= '0;
              w_last_r  <= '0;
            end else begin
              status_r <= is_mark ? ST_FULL : ST_NOT_FOUND;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_UPDATE: begin
          if (is_mark) valid_r[hit_idx_r] <= 1'b1;
          if (cmd_r == CMD_CLEAR) valid_r[hit_idx_r] <= 1'b0;
          // set up divide s / f, or judge directly
          dvd_r  <= js;
          dvs_r  <= jf;
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= '0;
          prod_r <= 64'(w_psucc_r) * 64'(chances_r);
          if (cmd_r == CMD_QUERY_CONN || cmd_r == CMD_QUERY_PATH) begin
            bad_r <= (js == '0) ? !(jf < chances_r) : 1'b0;
          end
        end
        S_DIV: begin
          if (dcnt_r == 6'(Cb)) begin
            bad_r <= !(quo_r > 1);
          end else begin
            dvd_r  <= {dvd_r[Cb-2:0], 1'b0};
            dcnt_r <= dcnt_r + 1'b1;
            if (rem_sh >= {1'b0, dvs_r}) begin
              rem_r <= Cb'(rem_sh - {1'b0, dvs_r});
              quo_r <= {quo_r[Cb-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh[Cb-1:0];
              quo_r <= {quo_r[Cb-2:0], 1'b0};
            end
          end
        end
        S_MUL: begin
          bad_r <= !((prod_r > 64'(w_pfail_r)) &&
                     (!(w_tmo_r > chances_r) || w_tmo_r < w_good_r));
        end
        S_TICK_UPD: idx_r <= idx_r + 1'b1;
        S_OUT: if (state_nxt == S_IDLE) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no new beat is taken while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept with pending result");
  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'd3) else $error("bad status code");
  // divider never runs past its width
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dcnt_r <= 6'(Cb)) else $error("divider overrun");
`endif
endmodule

[src/prt_ram.sv]
// Generic single-port RAM with registered read.
module prt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
